@@ design/block_range_add_range_sum_assert.svh @@
// Assertion macros shared by the block range-add / range-sum design.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BLOCK_RANGE_ADD_RANGE_SUM_ASSERT_SVH
`define BLOCK_RANGE_ADD_RANGE_SUM_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BRARS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brars same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define BRARS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brars next-cycle check failed");

`endif

@@ design/brars_pkg.sv @@
// Shared constants, types and state codes of the block range-add / range-sum engine.
// No dependencies; every other design file except the assertion macro header imports this package.
`timescale 1ns / 1ps

package brars_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int BLOCK_SIZE   = 32;
  localparam int NUM_BLOCKS   = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int OFF_W        = $clog2(BLOCK_SIZE);
  localparam int BLK_W        = IDX_W - OFF_W;
  localparam int CNT_W        = 11;
  localparam int DATA_W       = 64;
  localparam int MODE_W       = 2;
  localparam int MULT_W       = OFF_W + 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SPAN_HDR,
    S_SPAN_RUN,
    S_SPAN_FIX,
    S_BLK_RD,
    S_BLK_PEND,
    S_BLK_TOT,
    S_LD_RD,
    S_LD_OLD,
    S_LD_DIFF,
    S_LD_TOT,
    S_LD_ELEM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              elem_rd;
    logic [IDX_W-1:0]  elem_raddr;
    logic              elem_we;
    logic [IDX_W-1:0]  elem_waddr;
    logic              blk_rd;
    logic [BLK_W-1:0]  blk_raddr;
    logic              pend_we;
    logic              tot_we;
    logic [BLK_W-1:0]  blk_waddr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] elem;
    logic [DATA_W-1:0] pend;
    logic [DATA_W-1:0] tot;
  } mem_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [MULT_W-1:0] k;
  } alu_req_t;

endpackage

@@ design/brars_if.sv @@
// Handshake channel interfaces: request, response and configuration write.
// Depends on brars_pkg for field widths.
`timescale 1ns / 1ps

interface brars_req_if import brars_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [IDX_W-1:0]         index_low;
  logic [IDX_W-1:0]         index_high;
  logic signed [DATA_W-1:0] operand_value;

  modport source (output valid, mode, index_low, index_high, operand_value, input ready);
  modport sink   (input valid, mode, index_low, index_high, operand_value, output ready);
endinterface

interface brars_rsp_if import brars_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic signed [DATA_W-1:0] range_sum;

  modport source (output valid, status, range_sum, input ready);
  modport sink   (input valid, status, range_sum, output ready);
endinterface

interface brars_cfg_if import brars_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] element_count;

  modport source (output valid, element_count, input ready);
  modport sink   (input valid, element_count, output ready);
endinterface

@@ design/brars_alu.sv @@
// Shared multiply-add unit: result = a + b * k, with k a small signed factor.
// Depends on brars_pkg for the request type and widths.
`timescale 1ns / 1ps

module brars_alu import brars_pkg::*; (
  input  alu_req_t          alu_req,
  output logic [DATA_W-1:0] alu_res
);

  logic signed [DATA_W+MULT_W-1:0] prod;

  assign prod    = $signed(alu_req.b) * $signed(alu_req.k);
  assign alu_res = alu_req.a + prod[DATA_W-1:0];

endmodule

@@ design/brars_store.sv @@
// Element, pending-add and block-total memories with registered read data.
// Depends on brars_pkg for the request and response types.
`timescale 1ns / 1ps

module brars_store import brars_pkg::*; (
  input  logic     clk,
  input  mem_req_t mem_req,
  output mem_rsp_t mem_rsp
);

  logic [DATA_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [DATA_W-1:0] pend_mem [NUM_BLOCKS];
  logic [DATA_W-1:0] tot_mem  [NUM_BLOCKS];

  logic [DATA_W-1:0] elem_q_r;
  logic [DATA_W-1:0] pend_q_r;
  logic [DATA_W-1:0] tot_q_r;

  always_ff @(posedge clk) begin
    if (mem_req.elem_we) begin
      elem_mem[mem_req.elem_waddr] <= mem_req.wdata;
    end
    if (mem_req.elem_rd) begin
      elem_q_r <= elem_mem[mem_req.elem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.pend_we) begin
      pend_mem[mem_req.blk_waddr] <= mem_req.wdata;
    end
    if (mem_req.blk_rd) begin
      pend_q_r <= pend_mem[mem_req.blk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.tot_we) begin
      tot_mem[mem_req.blk_waddr] <= mem_req.wdata;
    end
    if (mem_req.blk_rd) begin
      tot_q_r <= tot_mem[mem_req.blk_raddr];
    end
  end

  assign mem_rsp.elem = elem_q_r;
  assign mem_rsp.pend = pend_q_r;
  assign mem_rsp.tot  = tot_q_r;

endmodule

@@ design/brars_ctrl.sv @@
// Sequencer: request decode, span and block walks, load steps, output register.
// Depends on brars_pkg, the channel interfaces and the assertion macro header.
`timescale 1ns / 1ps
`include "block_range_add_range_sum_assert.svh"

module brars_ctrl import brars_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  brars_req_if.sink         in_req,
  brars_cfg_if.sink         cfg_wr,
  brars_rsp_if.source       out_rsp,
  output mem_req_t          mem_req,
  input  mem_rsp_t          mem_rsp,
  output alu_req_t          alu_req,
  input  logic [DATA_W-1:0] alu_res
);

  localparam logic [MULT_W-1:0] K_ONE   = MULT_W'(1);
  localparam logic [MULT_W-1:0] K_NEG   = {MULT_W{1'b1}};
  localparam logic [MULT_W-1:0] K_BLOCK = MULT_W'(BLOCK_SIZE);

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  mode_t             mode_r, mode_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [DATA_W-1:0] c_r, c_nxt;
  logic              err_r, err_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] tmp_r, tmp_nxt;
  logic [IDX_W-1:0]  ptr_r, ptr_nxt;
  logic [IDX_W-1:0]  end_r, end_nxt;
  logic [OFF_W:0]    n_r, n_nxt;
  logic              seg_r, seg_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_sum_r, out_sum_nxt;

  logic              accept;
  logic              in_bad;
  logic [BLK_W-1:0]  in_lo_blk;
  logic [BLK_W-1:0]  in_hi_blk;
  logic [BLK_W-1:0]  lo_blk;
  logic [BLK_W-1:0]  hi_blk;
  logic [BLK_W-1:0]  cur_blk;
  logic              multi_blk;
  logic              blk_last;
  logic              out_free;

  assign in_req.ready  = (state_r == S_IDLE);
  assign accept        = in_req.valid && in_req.ready;
  assign cfg_wr.ready  = 1'b1;

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.range_sum = out_sum_r;

  assign in_lo_blk = in_req.index_low[IDX_W-1:OFF_W];
  assign in_hi_blk = in_req.index_high[IDX_W-1:OFF_W];
  assign lo_blk    = lo_r[IDX_W-1:OFF_W];
  assign hi_blk    = hi_r[IDX_W-1:OFF_W];
  assign cur_blk   = ptr_r[IDX_W-1:OFF_W];
  assign multi_blk = BLK_W'(hi_blk - lo_blk) > BLK_W'(1);
  assign blk_last  = (blk_r == BLK_W'(hi_blk - 1'b1));
  assign out_free  = !out_valid_r || out_rsp.ready;

  always_comb begin
    unique case (in_req.mode) inside
      MODE_LOAD: begin
        in_bad = CNT_W'(in_req.index_low) >= cnt_r;
      end
      MODE_ADD, MODE_QUERY: begin
        in_bad = (in_req.index_low > in_req.index_high) ||
                 (CNT_W'(in_req.index_high) >= cnt_r);
      end
      default: begin
        in_bad = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (cfg_wr.valid && cfg_wr.ready) begin
      cnt_nxt = (cfg_wr.element_count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                              : cfg_wr.element_count;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (ptr_r == IDX_W'(MAX_ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            state_nxt = S_DONE;
          end else if (in_req.mode == MODE_LOAD) begin
            state_nxt = S_LD_RD;
          end else begin
            state_nxt = S_SPAN_HDR;
          end
        end
      end
      S_SPAN_HDR: begin
        state_nxt = S_SPAN_RUN;
      end
      S_SPAN_RUN: begin
        if (ptr_r == end_r) begin
          state_nxt = S_SPAN_FIX;
        end
      end
      S_SPAN_FIX: begin
        if (seg_r || (lo_blk == hi_blk)) begin
          state_nxt = S_DONE;
        end else if (multi_blk) begin
          state_nxt = S_BLK_RD;
        end else begin
          state_nxt = S_SPAN_HDR;
        end
      end
      S_BLK_RD: begin
        state_nxt = S_BLK_PEND;
      end
      S_BLK_PEND: begin
        if (mode_r == MODE_ADD) begin
          state_nxt = S_BLK_TOT;
        end else if (blk_last) begin
          state_nxt = S_SPAN_HDR;
        end
      end
      S_BLK_TOT: begin
        state_nxt = blk_last ? S_SPAN_HDR : S_BLK_PEND;
      end
      S_LD_RD: begin
        state_nxt = S_LD_OLD;
      end
      S_LD_OLD: begin
        state_nxt = S_LD_DIFF;
      end
      S_LD_DIFF: begin
        state_nxt = S_LD_TOT;
      end
      S_LD_TOT: begin
        state_nxt = S_LD_ELEM;
      end
      S_LD_ELEM: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    mem_req        = '0;
    mem_req.wdata  = alu_res;
    alu_req        = '0;
    mode_nxt       = mode_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    c_nxt          = c_r;
    err_nxt        = err_r;
    acc_nxt        = acc_r;
    tmp_nxt        = tmp_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    n_nxt          = n_r;
    seg_nxt        = seg_r;
    blk_nxt        = blk_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_sum_nxt    = out_sum_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.wdata      = '0;
        mem_req.elem_we    = 1'b1;
        mem_req.elem_waddr = ptr_r;
        if ({1'b0, ptr_r} < (IDX_W + 1)'(NUM_BLOCKS)) begin
          mem_req.pend_we   = 1'b1;
          mem_req.tot_we    = 1'b1;
          mem_req.blk_waddr = ptr_r[BLK_W-1:0];
        end
        ptr_nxt = IDX_W'(ptr_r + 1'b1);
      end
      S_IDLE: begin
        if (accept) begin
          mode_nxt = mode_t'(in_req.mode);
          lo_nxt   = in_req.index_low;
          hi_nxt   = in_req.index_high;
          c_nxt    = in_req.operand_value;
          err_nxt  = in_bad;
          acc_nxt  = '0;
          ptr_nxt  = in_req.index_low;
          seg_nxt  = 1'b0;
          end_nxt  = (in_lo_blk == in_hi_blk) ? in_req.index_high
                                              : {in_lo_blk, {OFF_W{1'b1}}};
        end
      end
      S_SPAN_HDR: begin
        mem_req.elem_rd    = 1'b1;
        mem_req.elem_raddr = ptr_r;
        mem_req.blk_rd     = 1'b1;
        mem_req.blk_raddr  = cur_blk;
        n_nxt = (OFF_W + 1)'({1'b0, end_r[OFF_W-1:0]} - {1'b0, ptr_r[OFF_W-1:0]} + 1'b1);
      end
      S_SPAN_RUN: begin
        if (mode_r == MODE_ADD) begin
          alu_req.a          = mem_rsp.elem;
          alu_req.b          = c_r;
          alu_req.k          = K_ONE;
          mem_req.elem_we    = 1'b1;
          mem_req.elem_waddr = ptr_r;
        end else begin
          alu_req.a = acc_r;
          alu_req.b = mem_rsp.elem;
          alu_req.k = K_ONE;
          acc_nxt   = alu_res;
        end
        if (ptr_r != end_r) begin
          mem_req.elem_rd    = 1'b1;
          mem_req.elem_raddr = IDX_W'(ptr_r + 1'b1);
          ptr_nxt            = IDX_W'(ptr_r + 1'b1);
        end
      end
      S_SPAN_FIX: begin
        if (mode_r == MODE_ADD) begin
          alu_req.a         = mem_rsp.tot;
          alu_req.b         = c_r;
          alu_req.k         = MULT_W'(n_r);
          mem_req.tot_we    = 1'b1;
          mem_req.blk_waddr = cur_blk;
        end else begin
          alu_req.a = acc_r;
          alu_req.b = mem_rsp.pend;
          alu_req.k = MULT_W'(n_r);
          acc_nxt   = alu_res;
        end
        if (!seg_r && (lo_blk != hi_blk)) begin
          if (multi_blk) begin
            blk_nxt = BLK_W'(lo_blk + 1'b1);
          end else begin
            ptr_nxt = {hi_blk, {OFF_W{1'b0}}};
            end_nxt = hi_r;
            seg_nxt = 1'b1;
          end
        end
      end
      S_BLK_RD: begin
        mem_req.blk_rd    = 1'b1;
        mem_req.blk_raddr = blk_r;
      end
      S_BLK_PEND: begin
        if (mode_r == MODE_ADD) begin
          alu_req.a         = mem_rsp.pend;
          alu_req.b         = c_r;
          alu_req.k         = K_ONE;
          mem_req.pend_we   = 1'b1;
          mem_req.blk_waddr = blk_r;
        end else begin
          alu_req.a = acc_r;
          alu_req.b = mem_rsp.tot;
          alu_req.k = K_ONE;
          acc_nxt   = alu_res;
          if (blk_last) begin
            ptr_nxt = {hi_blk, {OFF_W{1'b0}}};
            end_nxt = hi_r;
            seg_nxt = 1'b1;
          end else begin
            mem_req.blk_rd    = 1'b1;
            mem_req.blk_raddr = BLK_W'(blk_r + 1'b1);
            blk_nxt           = BLK_W'(blk_r + 1'b1);
          end
        end
      end
      S_BLK_TOT: begin
        alu_req.a         = mem_rsp.tot;
        alu_req.b         = c_r;
        alu_req.k         = K_BLOCK;
        mem_req.tot_we    = 1'b1;
        mem_req.blk_waddr = blk_r;
        if (blk_last) begin
          ptr_nxt = {hi_blk, {OFF_W{1'b0}}};
          end_nxt = hi_r;
          seg_nxt = 1'b1;
        end else begin
          mem_req.blk_rd    = 1'b1;
          mem_req.blk_raddr = BLK_W'(blk_r + 1'b1);
          blk_nxt           = BLK_W'(blk_r + 1'b1);
        end
      end
      S_LD_RD: begin
        mem_req.elem_rd    = 1'b1;
        mem_req.elem_raddr = ptr_r;
        mem_req.blk_rd     = 1'b1;
        mem_req.blk_raddr  = cur_blk;
      end
      S_LD_OLD: begin
        alu_req.a = mem_rsp.elem;
        alu_req.b = mem_rsp.pend;
        alu_req.k = K_ONE;
        tmp_nxt   = alu_res;
      end
      S_LD_DIFF: begin
        alu_req.a = c_r;
        alu_req.b = tmp_r;
        alu_req.k = K_NEG;
        tmp_nxt   = alu_res;
      end
      S_LD_TOT: begin
        alu_req.a         = mem_rsp.tot;
        alu_req.b         = tmp_r;
        alu_req.k         = K_ONE;
        mem_req.tot_we    = 1'b1;
        mem_req.blk_waddr = cur_blk;
      end
      S_LD_ELEM: begin
        alu_req.a          = c_r;
        alu_req.b          = mem_rsp.pend;
        alu_req.k          = K_NEG;
        mem_req.elem_we    = 1'b1;
        mem_req.elem_waddr = ptr_r;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = err_r;
          out_sum_nxt    = acc_r;
        end
      end
      default: begin
        mem_req.wdata = alu_res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      cnt_r       <= CNT_W'(MAX_ELEMENTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    c_r          <= c_nxt;
    err_r        <= err_nxt;
    acc_r        <= acc_nxt;
    tmp_r        <= tmp_nxt;
    end_r        <= end_nxt;
    n_r          <= n_nxt;
    seg_r        <= seg_nxt;
    blk_r        <= blk_nxt;
    out_status_r <= out_status_nxt;
    out_sum_r    <= out_sum_nxt;
  end

  `BRARS_ASSERT_NXT(a_busy_after_accept, accept, state_r != S_IDLE)
  `BRARS_ASSERT_NXT(a_bad_request_skips, accept && in_bad, state_r == S_DONE)
  `BRARS_ASSERT_IMP(a_span_one_block, state_r == S_SPAN_RUN, cur_blk == end_r[IDX_W-1:OFF_W])
  `BRARS_ASSERT_IMP(a_span_order, state_r == S_SPAN_RUN, ptr_r <= end_r)
  `BRARS_ASSERT_IMP(a_idle_no_write, state_r == S_IDLE, !(mem_req.elem_we || mem_req.tot_we))

endmodule

@@ design/block_range_add_range_sum.sv @@
// Top level of the block range-add / range-sum engine.
// Depends on brars_pkg, the channel interfaces, brars_ctrl, brars_store and brars_alu.
//
// The engine keeps 1024 signed 64-bit elements in blocks of 32, each block with a
// running total and a pending add, and serves one request at a time: load one
// element, add a value over an inclusive index range, or return the wrapped sum over
// a range. Every request gets exactly one response; a bad range or index, or an
// unused mode, returns status 1 and changes nothing. After reset the engine clears its
// memories before the request channel goes ready; the configuration channel is always
// ready. A range add walks the elements of the partial blocks and updates the pending
// add and total of each whole block; a range query walks the partial-block elements and
// reads the total of each whole block. The time a request takes is set by the element
// walk, one element per cycle through the single read port of the element memory, and
// by the single shared multiply-add unit that every update and sum step goes through.
`timescale 1ns / 1ps

module block_range_add_range_sum import brars_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  brars_req_if.sink   in_req,
  brars_cfg_if.sink   cfg_wr,
  brars_rsp_if.source out_rsp
);

  mem_req_t          mem_req;
  mem_rsp_t          mem_rsp;
  alu_req_t          alu_req;
  logic [DATA_W-1:0] alu_res;

  brars_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .cfg_wr  (cfg_wr),
    .out_rsp (out_rsp),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp),
    .alu_req (alu_req),
    .alu_res (alu_res)
  );

  brars_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .mem_rsp (mem_rsp)
  );

  brars_alu u_alu (
    .alu_req (alu_req),
    .alu_res (alu_res)
  );

endmodule
